>>> hw/rtl/weighted_nearest_record_search_macros.svh
// Assertion macros shared by the search block.
`ifndef WEIGHTED_NEAREST_RECORD_SEARCH_MACROS_SVH
`define WEIGHTED_NEAREST_RECORD_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WNRS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WNRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/wnrs_pkg.sv
package wnrs_pkg;

	localparam int INDEX_BITS_DEF  = 24;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int IDX_EXT_W       = 32;
	localparam int CFG_DATA_W      = 24;
	localparam int CFG_INDEX_W     = 3;
	localparam int DIST_W          = 48;
	localparam int ANGLE_SHIFT     = 16;

	localparam logic [13:0] ANGLE_WEIGHT = 14'd10000;
	localparam logic [23:0] EXCL_RESET   = 24'hFFFFFF;
	localparam logic [15:0] THRESH_RESET = 16'hFD00;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_QUERY_X      = 3'd0,
		REG_QUERY_Y      = 3'd1,
		REG_QUERY_Z      = 3'd2,
		REG_QUERY_THETA  = 3'd3,
		REG_QUERY_PHI    = 3'd4,
		REG_QUERY_LENGTH = 3'd5,
		REG_EXCL_INDEX   = 3'd6,
		REG_COSMIC_THR   = 3'd7
	} cfg_reg_t;

	// Input word layout; the last member sits in the lowest bits.
	typedef struct packed {
		logic [63:0] record_tag;
		logic [23:0] record_index;
		logic [15:0] cosmic_score;
		logic [19:0] track_length;
		logic [15:0] azimuth;
		logic [15:0] polar_angle;
		logic [19:0] pos_z;
		logic [19:0] pos_y;
		logic [19:0] pos_x;
	} rec_t;

	// Result word layout; the last member sits in the lowest bits.
	typedef struct packed {
		logic [DIST_W-1:0] best_distance;
		logic [63:0]       best_tag;
		logic [19:0]       best_length;
		logic [15:0]       best_phi;
		logic [15:0]       best_theta;
		logic [19:0]       best_z;
		logic [19:0]       best_y;
		logic [19:0]       best_x;
	} res_t;

	localparam int IN_DATA_W  = $bits(rec_t);
	localparam int OUT_DATA_W = $bits(res_t);

	typedef struct packed {
		logic qual;
		logic last;
		res_t res;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

>>> hw/rtl/wnrs_front.sv
module wnrs_front #(
	parameter int INDEX_BITS = wnrs_pkg::INDEX_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wnrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wnrs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  wnrs_pkg::rec_t                      s_rec,
	input  logic                                s_cut,
	input  logic                                s_last,
	input  logic                                q_full,
	output logic                                q_push,
	output wnrs_pkg::entry_t                    q_entry
);

	localparam logic [wnrs_pkg::IDX_EXT_W-1:0] IDX_MASK = (INDEX_BITS >= wnrs_pkg::IDX_EXT_W) ?
		'1 : wnrs_pkg::IDX_EXT_W'((64'd1 << INDEX_BITS) - 64'd1);

	logic [19:0] qry_x_q, qry_y_q, qry_z_q, qry_len_q;
	logic [15:0] qry_theta_q, qry_phi_q, thr_q;
	logic [23:0] excl_q;

	logic             advance;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	wnrs_pkg::rec_t   rec_s1;
	logic             cut_s1, last_s1;
	wnrs_pkg::entry_t ent_s2, ent_s3, ent_s4, ent_s5;
	logic [19:0]      mag_s2 [6];
	logic [39:0]      sq_s3 [6];
	logic [39:0]      sq_s4 [4];
	logic [29:0]      ang_s4 [2];
	logic [40:0]      sum_a_s5, sum_b_s5;
	logic [30:0]      sum_c_s5;

	logic                              qual_s1;
	logic [wnrs_pkg::IDX_EXT_W-1:0]    idx_diff;
	wnrs_pkg::entry_t                  ent_nxt;
	logic [45:0]                       prod_theta, prod_phi;

	function automatic logic [19:0] mag20(input logic [19:0] a, input logic [19:0] b);
		logic [20:0] d;
		d = {a[19], a} - {b[19], b};
		if (d[20]) begin
			d = ~d + 21'd1;
		end
		return d[19:0];
	endfunction

	function automatic logic [15:0] mag16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] d;
		d = {a[15], a} - {b[15], b};
		if (d[16]) begin
			d = ~d + 17'd1;
		end
		return d[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qry_x_q     <= '0;
			qry_y_q     <= '0;
			qry_z_q     <= '0;
			qry_theta_q <= '0;
			qry_phi_q   <= '0;
			qry_len_q   <= '0;
			excl_q      <= wnrs_pkg::EXCL_RESET;
			thr_q       <= wnrs_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			case (wnrs_pkg::cfg_reg_t'(cfg_index))
				wnrs_pkg::REG_QUERY_X:      qry_x_q     <= cfg_data[19:0];
				wnrs_pkg::REG_QUERY_Y:      qry_y_q     <= cfg_data[19:0];
				wnrs_pkg::REG_QUERY_Z:      qry_z_q     <= cfg_data[19:0];
				wnrs_pkg::REG_QUERY_THETA:  qry_theta_q <= cfg_data[15:0];
				wnrs_pkg::REG_QUERY_PHI:    qry_phi_q   <= cfg_data[15:0];
				wnrs_pkg::REG_QUERY_LENGTH: qry_len_q   <= cfg_data[19:0];
				wnrs_pkg::REG_EXCL_INDEX:   excl_q      <= cfg_data[23:0];
				wnrs_pkg::REG_COSMIC_THR:   thr_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign advance  = !v_s5 || !q_full;
	assign s_tready = advance;
	assign q_push   = v_s5 && !q_full;

	always_comb begin
		idx_diff = (wnrs_pkg::IDX_EXT_W'(rec_s1.record_index) ^
			wnrs_pkg::IDX_EXT_W'(excl_q)) & IDX_MASK;
		qual_s1 = cut_s1 && ($signed(rec_s1.cosmic_score) > $signed(thr_q)) &&
			(idx_diff != '0);
		ent_nxt                   = '0;
		ent_nxt.qual              = qual_s1;
		ent_nxt.last              = last_s1;
		ent_nxt.res.best_x        = rec_s1.pos_x;
		ent_nxt.res.best_y        = rec_s1.pos_y;
		ent_nxt.res.best_z        = rec_s1.pos_z;
		ent_nxt.res.best_theta    = rec_s1.polar_angle;
		ent_nxt.res.best_phi      = rec_s1.azimuth;
		ent_nxt.res.best_length   = rec_s1.track_length;
		ent_nxt.res.best_tag      = rec_s1.record_tag;
		prod_theta = 46'(sq_s3[3][31:0]) * 46'(wnrs_pkg::ANGLE_WEIGHT);
		prod_phi   = 46'(sq_s3[4][31:0]) * 46'(wnrs_pkg::ANGLE_WEIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rec_s1    <= s_rec;
			cut_s1    <= s_cut;
			last_s1   <= s_last;
			ent_s2    <= ent_nxt;
			mag_s2[0] <= mag20(rec_s1.pos_x, qry_x_q);
			mag_s2[1] <= mag20(rec_s1.pos_y, qry_y_q);
			mag_s2[2] <= mag20(rec_s1.pos_z, qry_z_q);
			mag_s2[3] <= {4'd0, mag16(rec_s1.polar_angle, qry_theta_q)};
			mag_s2[4] <= {4'd0, mag16(rec_s1.azimuth, qry_phi_q)};
			mag_s2[5] <= mag20(rec_s1.track_length, qry_len_q);
			ent_s3    <= ent_s2;
			for (int i = 0; i < 6; i++) begin
				sq_s3[i] <= 40'(mag_s2[i]) * 40'(mag_s2[i]);
			end
			ent_s4    <= ent_s3;
			sq_s4[0]  <= sq_s3[0];
			sq_s4[1]  <= sq_s3[1];
			sq_s4[2]  <= sq_s3[2];
			sq_s4[3]  <= sq_s3[5];
			ang_s4[0] <= prod_theta[45:wnrs_pkg::ANGLE_SHIFT];
			ang_s4[1] <= prod_phi[45:wnrs_pkg::ANGLE_SHIFT];
			ent_s5    <= ent_s4;
			sum_a_s5  <= 41'(sq_s4[0]) + 41'(sq_s4[1]);
			sum_b_s5  <= 41'(sq_s4[2]) + 41'(sq_s4[3]);
			sum_c_s5  <= 31'(ang_s4[0]) + 31'(ang_s4[1]);
		end
	end

	always_comb begin
		q_entry                   = ent_s5;
		q_entry.res.best_distance = wnrs_pkg::DIST_W'(sum_a_s5) +
			wnrs_pkg::DIST_W'(sum_b_s5) + wnrs_pkg::DIST_W'(sum_c_s5);
	end

endmodule

>>> hw/rtl/wnrs_queue.sv
module wnrs_queue #(
	parameter int DEPTH = wnrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  wnrs_pkg::entry_t             din,
	input  logic                         pop,
	output wnrs_pkg::entry_t             dout,
	output wnrs_pkg::queue_stat_t        stat,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	wnrs_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign dout       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

>>> hw/rtl/wnrs_back.sv
module wnrs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  wnrs_pkg::entry_t q_head,
	output logic             q_pop,
	output logic             m_valid,
	input  logic             m_ready,
	output wnrs_pkg::res_t   m_res,
	output logic             m_found
);

	wnrs_pkg::res_t best_q, out_q, best_nxt, best_clr;
	logic           any_q, found_q, m_valid_q;
	logic           take, any_nxt;

	always_comb begin
		best_clr               = '0;
		best_clr.best_distance = '1;
		take     = q_head.qual && (!any_q ||
			(q_head.res.best_distance < best_q.best_distance));
		best_nxt = take ? q_head.res : best_q;
		any_nxt  = any_q || take;
		q_pop    = q_valid && (!q_head.last || !m_valid_q || m_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q    <= best_clr;
			any_q     <= 1'b0;
			out_q     <= '0;
			found_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (q_pop && q_head.last) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (q_head.last) begin
					out_q   <= any_nxt ? best_nxt : '0;
					found_q <= any_nxt;
					best_q  <= best_clr;
					any_q   <= 1'b0;
				end else begin
					best_q <= best_nxt;
					any_q  <= any_nxt;
				end
			end
		end
	end

	assign m_valid = m_valid_q;
	assign m_res   = out_q;
	assign m_found = found_q;

endmodule

>>> hw/rtl/weighted_nearest_record_search.sv
// Weighted nearest record search.
// Records arrive on the s_ channel, one word per record; s_tlast marks the
// final record of a search. Each record that passed its cuts, has a cosmic
// score above the threshold and is not the excluded index is scored against
// the query registers, and the closest one (the first on a tie) is kept.
// After the final record one result word leaves on the m_ channel; m_tuser is
// the found flag, and with no qualifying record the whole result is zero.
// The front end accepts one word per cycle while s_tready is high and scores
// it in a five-stage pipeline; a four-entry queue feeds the back end, which
// compares and keeps one entry per cycle unless a final one waits on m_tready.
// The user writes query registers through cfg_we, cfg_index and cfg_data only
// while no search is in flight; the block itself does not enforce this.
// Reset loads the register defaults, empties the pipeline and queue and
// clears the search. When the receiver holds m_tready low, a finished result
// waits in the output register while later records keep flowing until the
// next final record reaches the head of the queue; the queue then fills and
// s_tready drops.
`include "weighted_nearest_record_search_macros.svh"

module weighted_nearest_record_search #(
	parameter int INDEX_BITS  = wnrs_pkg::INDEX_BITS_DEF,
	parameter int QUEUE_DEPTH = wnrs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wnrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wnrs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pos_x, pos_y, pos_z, polar_angle, azimuth, track_length,
	// cosmic_score, record_index, record_tag
	input  logic [wnrs_pkg::IN_DATA_W-1:0]      s_tdata,
	// passed_cuts
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// best_x, best_y, best_z, best_theta, best_phi, best_length,
	// best_tag, best_distance
	output logic [wnrs_pkg::OUT_DATA_W-1:0]     m_tdata,
	// found
	output logic                                m_tuser
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

	logic                  q_push, q_pop;
	wnrs_pkg::entry_t      q_entry, q_head;
	wnrs_pkg::queue_stat_t q_stat;
	logic [CNT_W-1:0]      q_count;
	wnrs_pkg::res_t        m_res;

	wnrs_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_rec    (wnrs_pkg::rec_t'(s_tdata)),
		.s_cut    (s_tuser),
		.s_last   (s_tlast),
		.q_full   (q_stat.full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	wnrs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_entry),
		.pop   (q_pop),
		.dout  (q_head),
		.stat  (q_stat),
		.count (q_count)
	);

	wnrs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(!q_stat.empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_res  (m_res),
		.m_found(m_tuser)
	);

	assign m_tdata = m_res;

	`WNRS_ASSERT_SAME(a_stall_only_when_full, !s_tready, q_stat.full, "input stalled with queue room")
	`WNRS_ASSERT_SAME(a_pop_not_empty, q_pop, !q_stat.empty, "queue popped while empty")
	`WNRS_ASSERT_SAME(a_count_bound, 1'b1, q_count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
	`WNRS_ASSERT_SAME(a_empty_result_zero, m_tvalid && !m_tuser, m_tdata == '0, "nonzero empty result")
	`WNRS_ASSERT_NEXT(a_push_fills, q_push && q_stat.empty, !q_stat.empty, "pushed word lost")

endmodule

>>> bench/nearest_record_checker.sv
module nearest_record_checker
	import wnrs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,
	input  logic                   s_tuser,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_DATA_W-1:0]  m_tdata,
	input  logic                   m_tuser,
	output int                     errors,
	output int                     pending
);

	typedef struct packed {
		logic found;
		res_t res;
	} outcome_t;

	logic signed [19:0] q_x, q_y, q_z, q_len;
	logic signed [15:0] q_theta, q_phi, cosmic_thr;
	logic [23:0]        excl_index;

	logic [DIST_W-1:0] closest_dist;
	rec_t              closest_rec;
	logic              have_closest;

	outcome_t expected_best[$];
	int       mismatches = 0;

	assign errors = mismatches;

	function automatic longint unsigned sq_delta(longint a, longint b);
		longint d;
		d = a - b;
		if (d < 0) begin
			d = -d;
		end
		return d * d;
	endfunction

	// Angle terms are scaled and floored one at a time, never as a sum.
	function automatic logic [DIST_W-1:0] weighted_distance(rec_t r);
		longint unsigned sum;
		sum = sq_delta($signed(r.pos_x), q_x) + sq_delta($signed(r.pos_y), q_y)
			+ sq_delta($signed(r.pos_z), q_z) + sq_delta($signed(r.track_length), q_len)
			+ ((sq_delta($signed(r.polar_angle), q_theta) * ANGLE_WEIGHT) >> ANGLE_SHIFT)
			+ ((sq_delta($signed(r.azimuth), q_phi) * ANGLE_WEIGHT) >> ANGLE_SHIFT);
		return sum[DIST_W-1:0];
	endfunction

	task automatic clear_search();
		closest_dist = '1;
		closest_rec  = '0;
		have_closest = 1'b0;
	endtask

	task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch, got %0h expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rec_t              rec;
		outcome_t          got;
		outcome_t          want;
		logic [DIST_W-1:0] rec_dist;
		if (!arst_n) begin
			q_x        = '0;
			q_y        = '0;
			q_z        = '0;
			q_theta    = '0;
			q_phi      = '0;
			q_len      = '0;
			excl_index = EXCL_RESET;
			cosmic_thr = THRESH_RESET;
			clear_search();
			expected_best.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.found = m_tuser;
				got.res   = m_tdata;
				if (expected_best.size() == 0) begin
					flag_mismatch("unexpected result word, tag", got.res.best_tag, '0);
				end else begin
					want = expected_best.pop_front();
					if (got.found != want.found)
						flag_mismatch("found", 64'(got.found), 64'(want.found));
					if (got.res.best_x != want.res.best_x)
						flag_mismatch("best_x", 64'(got.res.best_x), 64'(want.res.best_x));
					if (got.res.best_y != want.res.best_y)
						flag_mismatch("best_y", 64'(got.res.best_y), 64'(want.res.best_y));
					if (got.res.best_z != want.res.best_z)
						flag_mismatch("best_z", 64'(got.res.best_z), 64'(want.res.best_z));
					if (got.res.best_theta != want.res.best_theta)
						flag_mismatch("best_theta", 64'(got.res.best_theta),
							64'(want.res.best_theta));
					if (got.res.best_phi != want.res.best_phi)
						flag_mismatch("best_phi", 64'(got.res.best_phi),
							64'(want.res.best_phi));
					if (got.res.best_length != want.res.best_length)
						flag_mismatch("best_length", 64'(got.res.best_length),
							64'(want.res.best_length));
					if (got.res.best_tag != want.res.best_tag)
						flag_mismatch("best_tag", got.res.best_tag, want.res.best_tag);
					if (got.res.best_distance != want.res.best_distance)
						flag_mismatch("best_distance", 64'(got.res.best_distance),
							64'(want.res.best_distance));
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_QUERY_X:      q_x        = cfg_data[19:0];
					REG_QUERY_Y:      q_y        = cfg_data[19:0];
					REG_QUERY_Z:      q_z        = cfg_data[19:0];
					REG_QUERY_THETA:  q_theta    = cfg_data[15:0];
					REG_QUERY_PHI:    q_phi      = cfg_data[15:0];
					REG_QUERY_LENGTH: q_len      = cfg_data[19:0];
					REG_EXCL_INDEX:   excl_index = cfg_data[23:0];
					REG_COSMIC_THR:   cosmic_thr = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				rec = s_tdata;
				if (s_tuser && $signed(rec.cosmic_score) > cosmic_thr
						&& rec.record_index != excl_index) begin
					rec_dist = weighted_distance(rec);
					if (!have_closest || rec_dist < closest_dist) begin
						closest_dist = rec_dist;
						closest_rec  = rec;
						have_closest = 1'b1;
					end
				end
				if (s_tlast) begin
					want = '0;
					if (have_closest) begin
						want.found             = 1'b1;
						want.res.best_x        = closest_rec.pos_x;
						want.res.best_y        = closest_rec.pos_y;
						want.res.best_z        = closest_rec.pos_z;
						want.res.best_theta    = closest_rec.polar_angle;
						want.res.best_phi      = closest_rec.azimuth;
						want.res.best_length   = closest_rec.track_length;
						want.res.best_tag      = closest_rec.record_tag;
						want.res.best_distance = closest_dist;
					end
					expected_best.push_back(want);
					clear_search();
				end
			end
			pending <= expected_best.size();
		end
	end

endmodule

>>> bench/tb_weighted_nearest_record_search.sv
module tb_weighted_nearest_record_search;
	import wnrs_pkg::*;

	localparam int QUIET_LIMIT = 1000;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_QUERY_X;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	// pos_x, pos_y, pos_z, polar_angle, azimuth, track_length,
	// cosmic_score, record_index, record_tag
	logic [IN_DATA_W-1:0]   s_tdata   = '0;
	// passed_cuts
	logic                   s_tuser   = 1'b0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	// best_x, best_y, best_z, best_theta, best_phi, best_length,
	// best_tag, best_distance
	logic [OUT_DATA_W-1:0]  m_tdata;
	// found
	logic                   m_tuser;

	int errors;
	int pending;
	int quiet_cycles = 0;
	bit s_steady     = 1'b0;
	bit m_steady     = 1'b0;

	logic [23:0] regs [8];

	weighted_nearest_record_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	nearest_record_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_weighted_nearest_record_search: errors");
			$finish;
		end
	end

	// Result receiver: a random stall before each word, with steady stretches.
	initial begin
		int gap;
		forever begin
			gap = m_steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if ($urandom_range(0, 4) == 0)
				m_steady = !m_steady;
		end
	end

	function automatic rec_t rec_of(int x, int y, int z, int th, int ph, int len, int cos,
			logic [23:0] idx, logic [63:0] tag);
		rec_t r;
		r.pos_x        = 20'(x);
		r.pos_y        = 20'(y);
		r.pos_z        = 20'(z);
		r.polar_angle  = 16'(th);
		r.azimuth      = 16'(ph);
		r.track_length = 20'(len);
		r.cosmic_score = 16'(cos);
		r.record_index = idx;
		r.record_tag   = tag;
		return r;
	endfunction

	function automatic logic [19:0] near_query(logic [23:0] center, int spread);
		return center[19:0] + 20'($urandom_range(0, 2 * spread)) - 20'(spread);
	endfunction

	// Most records sit close to the query so that the running minimum moves often.
	function automatic rec_t random_record();
		rec_t r;
		int   thr;
		thr = $signed(regs[REG_COSMIC_THR][15:0]);
		if ($urandom_range(0, 9) < 2) begin
			r.pos_x        = 20'($urandom);
			r.pos_y        = 20'($urandom);
			r.pos_z        = 20'($urandom);
			r.polar_angle  = 16'($urandom);
			r.azimuth      = 16'($urandom);
			r.track_length = 20'($urandom);
		end else begin
			r.pos_x        = near_query(regs[REG_QUERY_X], 40);
			r.pos_y        = near_query(regs[REG_QUERY_Y], 40);
			r.pos_z        = near_query(regs[REG_QUERY_Z], 40);
			r.polar_angle  = 16'(near_query(regs[REG_QUERY_THETA], 300));
			r.azimuth      = 16'(near_query(regs[REG_QUERY_PHI], 300));
			r.track_length = near_query(regs[REG_QUERY_LENGTH], 40);
		end
		case ($urandom_range(0, 9))
			0, 1: r.cosmic_score = 16'($urandom);
			2: r.cosmic_score = 16'(thr);
			default: begin
				if (thr < 32767)
					r.cosmic_score = 16'(thr + 1 + $urandom_range(0, 32766 - thr));
				else
					r.cosmic_score = 16'($urandom);
			end
		endcase
		r.record_index = ($urandom_range(0, 11) == 0) ? regs[REG_EXCL_INDEX] : 24'($urandom);
		r.record_tag   = {$urandom, $urandom};
		return r;
	endfunction

	task automatic send(rec_t r, logic cuts, logic last);
		int gap;
		gap = s_steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= r;
		s_tuser  <= cuts;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic load_query();
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= regs[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		rec_t r;
		rec_t prev;
		int   count;
		int   len;
		regs = '{24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 24'h00FD00};
		prev = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: threshold edge, excluded index, cut flag.
		send(rec_of(1, 2, 3, 4, 5, 6, -767, 0, 64'h0123_4567_89AB_CDEF), 1'b1, 1'b1);
		send(rec_of(10, 10, 10, 10, 10, 10, -768, 5, 64'h1), 1'b1, 1'b1);
		send(rec_of(0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 64'h2), 1'b1, 1'b1);
		send(rec_of(0, 0, 0, 0, 0, 0, 0, 7, 64'h3), 1'b0, 1'b1);
		// Ties keep the first record, including a tie on the final record.
		send(rec_of(100, 0, 0, 0, 0, 0, 0, 8, 64'h10), 1'b1, 1'b0);
		send(rec_of(0, 5, 0, 0, 0, 0, 0, 9, 64'h11), 1'b1, 1'b0);
		send(rec_of(3, 4, 0, 0, 0, 0, 0, 10, 64'h12), 1'b1, 1'b0);
		send(rec_of(0, 0, 4, 0, 0, 3, 0, 11, 64'h13), 1'b1, 1'b1);
		// Each angle term is floored on its own.
		send(rec_of(0, 0, 0, 3, -2, 0, 0, 12, 64'h20), 1'b1, 1'b0);
		send(rec_of(0, 0, 0, 2, -2, 0, 0, 13, 64'h21), 1'b1, 1'b1);
		drain();

		regs = '{24'h07FFFF, 24'h07FFFF, 24'h07FFFF, 24'h007FFF, 24'h007FFF, 24'h07FFFF,
			24'h000000, 24'h008000};
		load_query();
		send(rec_of(-524288, -524288, -524288, -32768, -32768, -524288, -32767, 1, '1),
			1'b1, 1'b0);
		send(rec_of(524287, 524287, 524287, 32767, 32767, 524287, 32767, 0, 64'h30),
			1'b1, 1'b0);
		send(rec_of(524287, 524287, 524287, 32767, 32767, 524287, 32767, 24'hFFFFFF, '0),
			1'b1, 1'b1);
		send(rec_of(524287, 524287, 524287, 32767, 32767, 524287, -32768, 3, 64'h31),
			1'b1, 1'b1);
		send(rec_of(-524288, -524288, -524288, -32768, -32768, -524288, 100, 2,
			64'hFFFF_0000_FFFF_0000), 1'b1, 1'b1);
		drain();

		regs = '{24'h080000, 24'h080000, 24'h080000, 24'h008000, 24'h008000, 24'h080000,
			24'h123456, 24'h007FFF};
		load_query();
		send(rec_of(-524288, -524288, -524288, -32768, -32768, -524288, 32767, 9, 64'h40),
			1'b1, 1'b1);
		drain();

		regs = '{24'h080000, 24'h07FFFF, 24'h000000, 24'h007FFF, 24'h008000, 24'h0ABCDE,
			24'hABCDEF, 24'h000000};
		load_query();
		send(rec_of(524287, -524288, 0, -32768, 32767, 0, 1, 24'hABCDEF, 64'h50),
			1'b1, 1'b0);
		send(rec_of(524287, -524288, 0, -32768, 32767, 0, 1, 24'hABCDEE, 64'h51),
			1'b1, 1'b0);
		send(rec_of(-524288, 524287, 0, 32767, -32768, 0, 0, 24'h000001, 64'h52),
			1'b1, 1'b1);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			for (int i = 0; i < 6; i++) begin
				case ($urandom_range(0, 5))
					0: regs[i] = (i == 3 || i == 4) ? 24'h008000 : 24'h080000;
					1: regs[i] = (i == 3 || i == 4) ? 24'h007FFF : 24'h07FFFF;
					2: regs[i] = 24'h0;
					default: regs[i] = (i == 3 || i == 4) ? 24'($urandom_range(0, 16'hFFFF))
						: 24'($urandom_range(0, 20'hFFFFF));
				endcase
			end
			case ($urandom_range(0, 5))
				0: regs[REG_EXCL_INDEX] = 24'h0;
				1: regs[REG_EXCL_INDEX] = 24'hFFFFFF;
				default: regs[REG_EXCL_INDEX] = 24'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: regs[REG_COSMIC_THR] = 24'h008000;
				1: regs[REG_COSMIC_THR] = 24'h007FFF;
				default: regs[REG_COSMIC_THR] = {8'h0, 16'($urandom_range(0, 2048) - 1024)};
			endcase
			load_query();
			count = 0;
			while (count < 115) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
					: $urandom_range(1, 8);
				if ($urandom_range(0, 3) == 0)
					s_steady = !s_steady;
				for (int k = 0; k < len; k++) begin
					r = random_record();
					if (k > 0 && $urandom_range(0, 5) == 0) begin
						r.pos_x        = prev.pos_x;
						r.pos_y        = prev.pos_y;
						r.pos_z        = prev.pos_z;
						r.polar_angle  = prev.polar_angle;
						r.azimuth      = prev.azimuth;
						r.track_length = prev.track_length;
					end
					send(r, $urandom_range(0, 7) != 0, k == len - 1);
					prev = r;
				end
				count += len;
			end
			drain();
		end

		if (errors == 0) begin
			$display("tb_weighted_nearest_record_search: clean");
		end else begin
			$display("tb_weighted_nearest_record_search: errors");
		end
		$finish;
	end

endmodule
